// ===== rtl/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared types for the vector normalisation unit
// Holds the data widths, the step counts of the two cell chains and the
// records that travel along them.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int CompW   = 32;            // component width, Q16.16
  localparam int SqW     = 2 * CompW;     // square and sum of squares
  localparam int RootW   = CompW;         // magnitude width
  localparam int RemW    = RootW + 3;     // square-root remainder width
  localparam int QuoW    = 31;            // quotient bits 30 down to 0
  localparam int DivRemW = RootW + 1;     // divider partial remainder width
  localparam int Lanes   = 3;
  localparam int SqrtSteps = RootW;
  localparam int DivSteps  = QuoW;

  // Record carried along the square-root chain.
  typedef struct packed {
    logic [RemW-1:0]             rem;
    logic [RootW-1:0]            root;
    logic [SqW-1:0]              rad;
    logic [Lanes-1:0][CompW-1:0] mag_abs;
    logic [Lanes-1:0]            neg;
    logic                        zero;
  } vn_sqrt_t;

  // Record carried along the divider chain.
  typedef struct packed {
    logic [Lanes-1:0][DivRemW-1:0] rem;
    logic [Lanes-1:0][QuoW-1:0]    quo;
    logic [Lanes-1:0]              nbit;
    logic [RootW-1:0]              mag;
    logic [Lanes-1:0]              neg;
    logic                          zero;
  } vn_div_t;

endpackage

// ===== rtl/vn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt_cell: one digit of the integer square root
// Brings down two radicand bits and decides one root bit, then registers.
// ----------------------------------------------------------------------------
module vn_sqrt_cell
  import vn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     valid_i,
  input  vn_sqrt_t data_i,
  output logic     valid_o,
  output vn_sqrt_t data_o
);

  logic              valid_r;
  vn_sqrt_t          data_r;
  vn_sqrt_t          data_nxt;
  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   trial;
  logic              take;

  always_comb begin
    rem_sh   = {data_i.rem[RemW-3:0], data_i.rad[SqW-1 -: 2]};
    trial    = {1'b0, data_i.root, 2'b01};
    take     = (rem_sh >= trial);
    data_nxt = data_i;
    data_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    data_nxt.root = {data_i.root[RootW-2:0], take};
    data_nxt.rad  = {data_i.rad[SqW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== rtl/vn_div_cell.sv =====
// ----------------------------------------------------------------------------
// vn_div_cell: one quotient bit for all three lanes
// Restoring division step against the shared magnitude, then registers.
// ----------------------------------------------------------------------------
module vn_div_cell
  import vn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    valid_i,
  input  vn_div_t data_i,
  output logic    valid_o,
  output vn_div_t data_o
);

  logic               valid_r;
  vn_div_t            data_r;
  vn_div_t            data_nxt;
  logic [DivRemW-1:0] rem_sh;
  logic [DivRemW-1:0] dvsr;
  logic               take;

  always_comb begin
    data_nxt = data_i;
    dvsr     = {1'b0, data_i.mag};
    rem_sh   = '0;
    take     = 1'b0;
    for (int l = 0; l < Lanes; l++) begin
      rem_sh = {data_i.rem[l][DivRemW-2:0], data_i.nbit[l]};
      take   = (rem_sh >= dvsr);
      data_nxt.rem[l] = take ? (rem_sh - dvsr) : rem_sh;
      data_nxt.quo[l] = {data_i.quo[l][QuoW-2:0], take};
    end
    // Only the first step brings down a dividend bit; the rest are zeros.
    data_nxt.nbit = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

// ===== rtl/vector3_normalize_unit.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_unit: 3-D vector normalisation
// Returns the magnitude (Q16.16) and the unit vector (Q1.30, truncated) of a
// signed Q16.16 vector, with a flag for the zero vector.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Handshake
//   request   in_comp_x, in_comp_y, in_comp_z         start high, busy low
//   result    out_unit_x/y/z, out_magnitude,          out_valid, one cycle
//             out_zero_error
//
// One request is taken every cycle; busy is held low.
// The pipe is three input stages (absolute value, squares, sum), 32
// square-root cells, 31 divider cells and the output register. The two
// cell chains make up most of its length.
// Reset clears the valid bits along the pipe only.
// The receiver cannot stall, so results leave on out_valid without waiting.
//
module vector3_normalize_unit
  import vn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CompW-1:0] in_comp_x,
  input  logic signed [CompW-1:0] in_comp_y,
  input  logic signed [CompW-1:0] in_comp_z,
  output logic                    out_valid,
  output logic signed [CompW-1:0] out_unit_x,
  output logic signed [CompW-1:0] out_unit_y,
  output logic signed [CompW-1:0] out_unit_z,
  output logic        [CompW-1:0] out_magnitude,
  output logic                    out_zero_error
);

  // The pipe never holds requests back.
  assign busy = 1'b0;

  // Stage 1: absolute values and signs. The most negative component
  // becomes 2^31, which still fits in 32 unsigned bits.
  logic                        s1_valid_r;
  logic [Lanes-1:0][CompW-1:0] s1_abs_r;
  logic [Lanes-1:0]            s1_neg_r;
  logic [Lanes-1:0][CompW-1:0] comp;

  assign comp[0] = in_comp_x;
  assign comp[1] = in_comp_y;
  assign comp[2] = in_comp_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
    for (int l = 0; l < Lanes; l++) begin
      s1_neg_r[l] <= comp[l][CompW-1];
      s1_abs_r[l] <= comp[l][CompW-1] ? (~comp[l] + 1'b1) : comp[l];
    end
  end

  // Stage 2: one 32 by 32 multiplier per component.
  logic                        s2_valid_r;
  logic [Lanes-1:0][SqW-1:0]   s2_sq_r;
  logic [Lanes-1:0][CompW-1:0] s2_abs_r;
  logic [Lanes-1:0]            s2_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    for (int l = 0; l < Lanes; l++) begin
      s2_sq_r[l] <= SqW'(s1_abs_r[l]) * SqW'(s1_abs_r[l]);
    end
    s2_abs_r <= s1_abs_r;
    s2_neg_r <= s1_neg_r;
  end

  // Stage 3: the sum of squares, at most 3 * 2^62, fits in 64 bits. It is
  // loaded straight into the first square-root record.
  logic     s3_valid_r;
  vn_sqrt_t s3_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_data_r.rem     <= '0;
    s3_data_r.root    <= '0;
    s3_data_r.rad     <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    s3_data_r.mag_abs <= s2_abs_r;
    s3_data_r.neg     <= s2_neg_r;
    s3_data_r.zero    <= (s2_abs_r == '0);
  end

  // Square-root chain: each cell settles one magnitude bit, MSB first.
  logic     [SqrtSteps:0] sq_valid;
  vn_sqrt_t [SqrtSteps:0] sq_data;

  assign sq_valid[0] = s3_valid_r;
  assign sq_data[0]  = s3_data_r;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (sq_valid[i]),
      .data_i  (sq_data[i]),
      .valid_o (sq_valid[i+1]),
      .data_o  (sq_data[i+1])
    );
  end

  // Divider set-up. The dividend is |c| << 30; since the magnitude is at
  // least |c|, the top part |c| >> 1 is already below it and only quotient
  // bits 30 down to 0 remain. Bit 30 of the dividend is |c|[0]; the rest
  // are zero.
  vn_div_t div_init;

  always_comb begin
    div_init.mag  = sq_data[SqrtSteps].root;
    div_init.neg  = sq_data[SqrtSteps].neg;
    div_init.zero = sq_data[SqrtSteps].zero;
    for (int l = 0; l < Lanes; l++) begin
      div_init.rem[l]  = DivRemW'(sq_data[SqrtSteps].mag_abs[l][CompW-1:1]);
      div_init.quo[l]  = '0;
      div_init.nbit[l] = sq_data[SqrtSteps].mag_abs[l][0];
    end
  end

  // Divider chain: each cell settles one quotient bit in all three lanes.
  logic    [DivSteps:0] dv_valid;
  vn_div_t [DivSteps:0] dv_data;

  assign dv_valid[0] = sq_valid[SqrtSteps];
  assign dv_data[0]  = div_init;

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    vn_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (dv_valid[i]),
      .data_i  (dv_data[i]),
      .valid_o (dv_valid[i+1]),
      .data_o  (dv_data[i+1])
    );
  end

  // Output register: restore signs, and force the unit vector to zero for
  // the zero vector, where the divider ran against a zero magnitude.
  logic                        out_valid_r;
  logic [Lanes-1:0][CompW-1:0] unit_r;
  logic [Lanes-1:0][CompW-1:0] unit_nxt;
  logic [CompW-1:0]            mag_r;
  logic                        zero_r;
  vn_div_t                     dv_last;

  assign dv_last = dv_data[DivSteps];

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      if (dv_last.zero) begin
        unit_nxt[l] = '0;
      end else if (dv_last.neg[l]) begin
        unit_nxt[l] = ~CompW'(dv_last.quo[l]) + 1'b1;
      end else begin
        unit_nxt[l] = CompW'(dv_last.quo[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid[DivSteps];
    end
    unit_r <= unit_nxt;
    mag_r  <= dv_last.mag;
    zero_r <= dv_last.zero;
  end

  assign out_valid      = out_valid_r;
  assign out_unit_x     = unit_r[0];
  assign out_unit_y     = unit_r[1];
  assign out_unit_z     = unit_r[2];
  assign out_magnitude  = mag_r;
  assign out_zero_error = zero_r;

endmodule

// ===== tb/sv/vector3_normalize_unit_test.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_unit_test: self-checking bench for the normalisation unit
// Drives vectors through the command interface, predicts the magnitude and
// unit vector of each request and compares every strobed result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module vector3_normalize_unit_test
  import vn_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One request as it is driven onto the input ports.
  typedef struct {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic signed [CompW-1:0] z;
  } vec_req_t;

  // One normalised result as the block should return it.
  typedef struct {
    logic signed [CompW-1:0] ux;
    logic signed [CompW-1:0] uy;
    logic signed [CompW-1:0] uz;
    logic        [CompW-1:0] mag;
    logic                    zero;
  } norm_res_t;

  localparam int Latency    = 67;
  localparam int CycleLimit = 200000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [CompW-1:0] in_comp_x = '0;
  logic signed [CompW-1:0] in_comp_y = '0;
  logic signed [CompW-1:0] in_comp_z = '0;
  logic                    out_valid;
  logic signed [CompW-1:0] out_unit_x;
  logic signed [CompW-1:0] out_unit_y;
  logic signed [CompW-1:0] out_unit_z;
  logic        [CompW-1:0] out_magnitude;
  logic                    out_zero_error;

  vec_req_t  pending_reqs[$];
  norm_res_t expected_norms[$];
  int        send_idle_pct = 22;
  bit        drain_hold = 1'b0;   // sender holds off new requests
  int        fail_count = 0;
  int        cycle_count = 0;

  vector3_normalize_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_comp_x      (in_comp_x),
    .in_comp_y      (in_comp_y),
    .in_comp_z      (in_comp_z),
    .out_valid      (out_valid),
    .out_unit_x     (out_unit_x),
    .out_unit_y     (out_unit_y),
    .out_unit_z     (out_unit_z),
    .out_magnitude  (out_magnitude),
    .out_zero_error (out_zero_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Floor of the square root of a 64-bit value, found bit by bit from the top.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Component over magnitude in Q1.30, truncated toward zero.
  function automatic logic signed [CompW-1:0] unit_component(
      logic signed [CompW-1:0] c, logic [63:0] mag);
    logic [63:0] a;
    logic [63:0] q;
    a = c[CompW-1] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
    q = (a << 30) / mag;
    if (c[CompW-1]) q = -q;
    return q[CompW-1:0];
  endfunction

  function automatic norm_res_t normalise(vec_req_t r);
    norm_res_t   res;
    logic [63:0] ax, ay, az, sum, mag;
    ax  = r.x[CompW-1] ? (64'h1_0000_0000 - {32'd0, r.x}) : {32'd0, r.x};
    ay  = r.y[CompW-1] ? (64'h1_0000_0000 - {32'd0, r.y}) : {32'd0, r.y};
    az  = r.z[CompW-1] ? (64'h1_0000_0000 - {32'd0, r.z}) : {32'd0, r.z};
    sum = ax * ax + ay * ay + az * az;
    if (sum == 0) begin
      res = '{ux: '0, uy: '0, uz: '0, mag: '0, zero: 1'b1};
    end else begin
      mag      = floor_sqrt(sum);
      res.ux   = unit_component(r.x, mag);
      res.uy   = unit_component(r.y, mag);
      res.uz   = unit_component(r.z, mag);
      res.mag  = mag[CompW-1:0];
      res.zero = 1'b0;
    end
    return res;
  endfunction

  // Random component: full range in four draws of ten, with small magnitudes,
  // zero and the extremes mixed in so that short vectors and rounding edges are seen.
  function automatic logic signed [CompW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3, 4:    return $signed(32'($urandom_range(0, 40))) - 20;
      5:       return $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_req(logic signed [CompW-1:0] x,
                                  logic signed [CompW-1:0] y,
                                  logic signed [CompW-1:0] z);
    pending_reqs.push_back('{x: x, y: y, z: z});
  endfunction

  // Driver: a request is taken on an edge where start is high and busy low.
  // The request on the ports stays at the head of the queue until it is
  // taken, so after the pop the head is always the next one to drive.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_norms.push_back(normalise('{x: in_comp_x, y: in_comp_y, z: in_comp_z}));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() != 0 && !drain_hold &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        vec_req_t nxt;
        nxt = pending_reqs[0];
        start     <= 1'b1;
        in_comp_x <= nxt.x;
        in_comp_y <= nxt.y;
        in_comp_z <= nxt.z;
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: results cannot be held off, so each strobe is checked at once.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (expected_norms.size() == 0) begin
        $error("unexpected result: no request outstanding");
        fail_count++;
      end else begin
        norm_res_t want;
        want = expected_norms.pop_front();
        if (out_unit_x !== want.ux) begin
          $error("unit_x: expected %0d, got %0d", want.ux, out_unit_x);
          fail_count++;
        end
        if (out_unit_y !== want.uy) begin
          $error("unit_y: expected %0d, got %0d", want.uy, out_unit_y);
          fail_count++;
        end
        if (out_unit_z !== want.uz) begin
          $error("unit_z: expected %0d, got %0d", want.uz, out_unit_z);
          fail_count++;
        end
        if (out_magnitude !== want.mag) begin
          $error("magnitude: expected %0d, got %0d", want.mag, out_magnitude);
          fail_count++;
        end
        if (out_zero_error !== want.zero) begin
          $error("zero_error: expected %0d, got %0d", want.zero, out_zero_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog against a hung pipe.
  always @(posedge clk) begin
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || expected_norms.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: zero vector, extremes, single axes, short vectors
    // where the rounded-down magnitude gives a full-scale unit component.
    add_req(0, 0, 0);
    add_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    add_req(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    add_req(32'sh8000_0000, 0, 0);
    add_req(0, 32'sh7fff_ffff, 0);
    add_req(0, 0, -1);
    add_req(1, 0, 0);
    add_req(1, 1, 0);
    add_req(1, 1, 1);
    add_req(-1, 1, -1);
    add_req(3, 4, 0);
    add_req(2, -1, 1);
    add_req(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    add_req(32'sh8000_0000, 32'sh7fff_ffff, 1);
    add_req(-1, -1, -1);
    add_req(32'shffff_0000, 0, 32'sh0000_ffff);
    add_req(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f);

    // First phase: the sender idles about a fifth of the time.
    for (int i = 0; i < 300; i++) add_req(rand_comp(), rand_comp(), rand_comp());
    wait_drained();

    // Hold the sender off for a random pause once every result is back, then
    // resume with a much idler sender.
    drain_hold = 1'b1;
    repeat ($urandom_range(1, 5)) @(posedge clk);
    drain_hold = 1'b0;
    send_idle_pct = 81;
    for (int i = 0; i < 300; i++) add_req(rand_comp(), rand_comp(), rand_comp());
    wait_drained();

    // Last phase: a request on every edge.
    send_idle_pct = 0;
    for (int i = 0; i < 350; i++) add_req(rand_comp(), rand_comp(), rand_comp());
    wait_drained();
    repeat (Latency + 10) @(posedge clk);

    if (fail_count == 0 && expected_norms.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
